[sv/assert_macros.svh]
// Assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the module's clock and reset
`define BFA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator implication check failed");

// next-cycle implication on the module's clock and reset
`define BFA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator next-cycle check failed");

`endif

[sv/bfa_pkg.sv]
// Shared types and constants of the best-fit block allocator
package bfa_pkg;

   localparam int BLOCKS_DEF = 64;
   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int SIZE_W     = 16;
   localparam int SUM_W      = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_wr;
      logic load_rsp;
      logic scan_init;
      logic scan_rd;
      logic commit;
   } cmd_type;

endpackage

[sv/best_fit_block_allocator_top.sv]
// Load word: result registered in the cycle after acceptance, busy stays low, one word per cycle.
// Allocation word: a scan of n = min(block_count, BLOCKS) entries, one read a cycle, then
// wait and commit states (commit directly when n is zero); busy is high from scan to commit.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset, then a clearing pass over all BLOCKS entries zeroes the size memory
// with busy high; csr writes are taken throughout.
module best_fit_block_allocator_top #(
   parameter int BLOCKS = bfa_pkg::BLOCKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [bfa_pkg::INDEX_W-1:0] req_block_index,
   input  logic [bfa_pkg::SIZE_W-1:0]  req_size,
   output logic                        rsp_valid,
   output logic                        rsp_granted,
   output logic [bfa_pkg::INDEX_W-1:0] rsp_chosen_block,
   output logic [bfa_pkg::SIZE_W-1:0]  rsp_leftover,
   output logic [bfa_pkg::SUM_W-1:0]   rsp_total_leftover,
   input  logic                        csr_we,
   input  logic [bfa_pkg::COUNT_W-1:0] csr_wdata
);
   import bfa_pkg::*;

   localparam int AW = $clog2(BLOCKS);

   cmd_type       cmd;
   logic [AW-1:0] addr;

   bfa_controller #(
      .BLOCKS (BLOCKS),
      .AW     (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_op    (req_op),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .addr      (addr)
   );

   bfa_datapath #(
      .BLOCKS (BLOCKS),
      .AW     (AW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .addr               (addr),
      .req_block_index    (req_block_index),
      .req_size           (req_size),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_leftover       (rsp_leftover),
      .rsp_total_leftover (rsp_total_leftover)
   );

endmodule

[sv/bfa_datapath.sv]
// Size memory, best-fit tracking, running total and result word registers
`include "assert_macros.svh"

module bfa_datapath #(
   parameter int BLOCKS = bfa_pkg::BLOCKS_DEF,
   parameter int AW     = $clog2(BLOCKS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfa_pkg::cmd_type            cmd,
   input  logic [AW-1:0]               addr,
   input  logic [bfa_pkg::INDEX_W-1:0] req_block_index,
   input  logic [bfa_pkg::SIZE_W-1:0]  req_size,
   output logic                        rsp_valid,
   output logic                        rsp_granted,
   output logic [bfa_pkg::INDEX_W-1:0] rsp_chosen_block,
   output logic [bfa_pkg::SIZE_W-1:0]  rsp_leftover,
   output logic [bfa_pkg::SUM_W-1:0]   rsp_total_leftover
);
   import bfa_pkg::*;

   localparam int IW = ((INDEX_W > AW) ? INDEX_W : AW) + 1;

   logic [SIZE_W-1:0]  mem_ff [BLOCKS];
   logic [SIZE_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic               found_ff, found_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_granted_ff;
   logic [INDEX_W-1:0] rsp_chosen_ff;
   logic [SIZE_W-1:0]  rsp_leftover_ff;
   logic [SUM_W-1:0]   rsp_total_ff;

   logic [IW-1:0]      idx_ext;
   logic               idx_in_range;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [SIZE_W-1:0]  wr_data;
   logic [SIZE_W-1:0]  left;
   logic [SUM_W:0]     sum_wide;
   logic               fit;

   assign idx_ext      = IW'(req_block_index);
   assign idx_in_range = idx_ext < IW'(BLOCKS);
   assign left         = best_size_ff - size_ff;
   assign sum_wide     = {1'b0, sum_ff} + (SUM_W + 1)'(left);
   assign fit          = rd_valid_ff && (rd_data_ff >= size_ff)
                         && (!found_ff || (best_size_ff > rd_data_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.load_wr) begin
         wr_en   = idx_in_range;
         wr_addr = AW'(idx_ext);
         wr_data = req_size;
      end else if (cmd.commit) begin
         wr_en   = found_ff;
         wr_addr = best_idx_ff;
         wr_data = left;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
      rd_idx_ff  <= addr;
   end

   always_comb begin
      found_in     = found_ff;
      best_size_in = best_size_ff;
      best_idx_in  = best_idx_ff;
      sum_in       = sum_ff;
      if (cmd.scan_init) begin
         found_in = 1'b0;
      end else if (fit) begin
         found_in     = 1'b1;
         best_size_in = rd_data_ff;
         best_idx_in  = rd_idx_ff;
      end
      if (cmd.commit && found_ff) begin
         sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.scan_rd;
         found_ff     <= found_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= cmd.commit || cmd.load_rsp;
      end
   end

   always_ff @(posedge clock) begin
      best_size_ff <= best_size_in;
      best_idx_ff  <= best_idx_in;
      if (cmd.scan_init) begin
         size_ff <= req_size;
      end
      if (cmd.commit) begin
         rsp_granted_ff  <= found_ff;
         rsp_chosen_ff   <= found_ff ? INDEX_W'(best_idx_ff) : '0;
         rsp_leftover_ff <= found_ff ? left : '0;
         rsp_total_ff    <= sum_in;
      end else if (cmd.load_rsp) begin
         rsp_granted_ff  <= 1'b0;
         rsp_chosen_ff   <= '0;
         rsp_leftover_ff <= '0;
         rsp_total_ff    <= sum_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_chosen_block   = rsp_chosen_ff;
   assign rsp_leftover       = rsp_leftover_ff;
   assign rsp_total_leftover = rsp_total_ff;

   `BFA_ASSERT_NXT(a_commit_word, cmd.commit || cmd.load_rsp, rsp_valid_ff)
   `BFA_ASSERT_NXT(a_grant_follows_find, cmd.commit && found_ff, rsp_granted_ff)
   `BFA_ASSERT_IMP(a_refusal_clean, rsp_valid_ff && !rsp_granted_ff,
      rsp_leftover_ff == '0 && rsp_chosen_ff == '0)

endmodule

[sv/bfa_controller.sv]
// Sequencer for memory clearing, loads and the best-fit scan
`include "assert_macros.svh"

module bfa_controller #(
   parameter int BLOCKS = bfa_pkg::BLOCKS_DEF,
   parameter int AW     = $clog2(BLOCKS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic                        csr_we,
   input  logic [bfa_pkg::COUNT_W-1:0] csr_wdata,
   output bfa_pkg::cmd_type            cmd,
   output logic [AW-1:0]               addr
);
   import bfa_pkg::*;

   localparam int LW = ($clog2(BLOCKS + 1) > COUNT_W) ? $clog2(BLOCKS + 1) : COUNT_W;

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [COUNT_W-1:0] count_ff;

   logic [LW-1:0]      count_ext;
   logic [LW-1:0]      limit;
   logic [AW-1:0]      last_addr;
   logic               accept;

   assign count_ext = LW'(count_ff);
   assign limit     = (count_ext > LW'(BLOCKS)) ? LW'(BLOCKS) : count_ext;
   assign last_addr = AW'(limit - LW'(1));
   assign accept    = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         count_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (cnt_ff == AW'(BLOCKS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_wr  = 1'b1;
                  cmd.load_rsp = 1'b1;
               end else begin
                  cmd.scan_init = 1'b1;
                  cnt_in        = '0;
                  state_in      = (limit == '0) ? ST_COMMIT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == last_addr) begin
               state_in = ST_WAIT;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_WAIT: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign addr = cnt_ff;

   `BFA_ASSERT_NXT(a_alloc_busy, accept && req_op == OP_ALLOC, busy)
   `BFA_ASSERT_NXT(a_commit_idle, cmd.commit, state_ff == ST_IDLE)
   `BFA_ASSERT_NXT(a_scan_end, cmd.scan_rd && cnt_ff == last_addr, state_ff == ST_WAIT)

endmodule
